// ===== rtl/svn_pkg.sv =====
package svn_pkg;

	localparam int POS_W  = 16;
	localparam int VEC_W  = 35;
	localparam int Q14_W  = 16;
	localparam int SQ_W   = 64;
	localparam int LEN_W  = 31;
	localparam int DIV_W  = 45;
	localparam int QUO_W  = 15;
	localparam int MAG_W  = 30;
	localparam int FRAC_W = 14;
	localparam int CNT_W  = 11;

	typedef logic signed [VEC_W-1:0] vec_t;
	typedef logic signed [Q14_W-1:0] q14_t;
	typedef logic signed [POS_W-1:0] pos_t;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_CLEAR = 2'd1,
		OP_ADD   = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_POS_A,
		ST_POS_B,
		ST_POS_C,
		ST_POS_CAP,
		ST_CROSS,
		ST_RD_ADDR,
		ST_RD_DATA,
		ST_NORM_START,
		ST_NORM_WAIT,
		ST_ACC_RD,
		ST_ACC_WR,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		NS_IDLE,
		NS_SHIFT,
		NS_SQ,
		NS_SQRT,
		NS_DIVSET,
		NS_DIV,
		NS_DONE
	} nstate_t;

endpackage

// ===== rtl/svn_ram.sv =====
module svn_ram #(
	parameter int W = 48,
	parameter int D = 1024
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/svn_norm.sv =====
module svn_norm (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  svn_pkg::vec_t v0,
	input  svn_pkg::vec_t v1,
	input  svn_pkg::vec_t v2,
	output logic          done,
	output svn_pkg::q14_t n0,
	output svn_pkg::q14_t n1,
	output svn_pkg::q14_t n2
);

	import svn_pkg::*;

	nstate_t state_q, state_d;

	logic [VEC_W-1:0]  mag_q [3];
	logic              neg_q [3];
	q14_t              res_q [3];
	logic [1:0]        cnt_q;
	logic [1:0]        comp_q;
	logic [3:0]        step_q;
	logic [2*MAG_W-1:0] prod_q;
	logic [SQ_W-1:0]   sum_q;
	logic [SQ_W-1:0]   root_q;
	logic [SQ_W-1:0]   bit_q;
	logic [LEN_W-1:0]  len_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  den_q;
	logic [QUO_W-1:0]  quo_q;

	logic              big;
	logic [MAG_W-1:0]  sq_op;
	logic [SQ_W-1:0]   trial;
	logic              ge;
	logic [QUO_W-1:0]  quo_next;
	logic [Q14_W-1:0]  quo_ext;

	assign big = (|mag_q[0][VEC_W-1:MAG_W]) | (|mag_q[1][VEC_W-1:MAG_W])
		| (|mag_q[2][VEC_W-1:MAG_W]);
	assign trial    = root_q + bit_q;
	assign ge       = rem_q >= den_q;
	assign quo_next = {quo_q[QUO_W-2:0], ge};
	assign quo_ext  = {1'b0, quo_next};

	always_comb begin
		unique case (cnt_q)
			2'd0:    sq_op = mag_q[0][MAG_W-1:0];
			2'd1:    sq_op = mag_q[1][MAG_W-1:0];
			2'd2:    sq_op = mag_q[2][MAG_W-1:0];
			default: sq_op = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= NS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		done    = 1'b0;
		unique case (state_q)
			NS_IDLE:   if (start) state_d = NS_SHIFT;
			NS_SHIFT:  if (!big) state_d = NS_SQ;
			NS_SQ:     if (cnt_q == 2'd3) state_d = NS_SQRT;
			NS_SQRT:   if (bit_q == '0) state_d = NS_DIVSET;
			NS_DIVSET: state_d = NS_DIV;
			NS_DIV: begin
				if (step_q == 4'(QUO_W - 1)) begin
					state_d = (comp_q == 2'd2) ? NS_DONE : NS_DIVSET;
				end
			end
			NS_DONE: begin
				done    = 1'b1;
				state_d = NS_IDLE;
			end
			default: state_d = NS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			comp_q <= '0;
			step_q <= '0;
		end else begin
			unique case (state_q)
				NS_SHIFT: cnt_q <= '0;
				NS_SQ:    cnt_q <= cnt_q + 2'd1;
				NS_SQRT:  comp_q <= '0;
				NS_DIVSET: step_q <= '0;
				NS_DIV: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'(QUO_W - 1)) comp_q <= comp_q + 2'd1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			NS_IDLE: begin
				if (start) begin
					mag_q[0] <= v0[VEC_W-1] ? VEC_W'(-v0) : VEC_W'(v0);
					mag_q[1] <= v1[VEC_W-1] ? VEC_W'(-v1) : VEC_W'(v1);
					mag_q[2] <= v2[VEC_W-1] ? VEC_W'(-v2) : VEC_W'(v2);
					neg_q[0] <= v0[VEC_W-1];
					neg_q[1] <= v1[VEC_W-1];
					neg_q[2] <= v2[VEC_W-1];
				end
			end
			NS_SHIFT: begin
				if (big) begin
					mag_q[0] <= mag_q[0] >> 1;
					mag_q[1] <= mag_q[1] >> 1;
					mag_q[2] <= mag_q[2] >> 1;
				end
				sum_q <= '0;
			end
			NS_SQ: begin
				prod_q <= sq_op * sq_op;
				if (cnt_q != 2'd0) sum_q <= sum_q + SQ_W'(prod_q);
				root_q <= '0;
				bit_q  <= SQ_W'(1) << 62;
			end
			NS_SQRT: begin
				if (bit_q != '0) begin
					if (sum_q >= trial) begin
						sum_q  <= sum_q - trial;
						root_q <= (root_q >> 1) + bit_q;
					end else begin
						root_q <= root_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end else begin
					len_q <= root_q[LEN_W-1:0];
				end
			end
			NS_DIVSET: begin
				rem_q <= DIV_W'({mag_q[comp_q][MAG_W-1:0], {FRAC_W{1'b0}}})
					+ DIV_W'(len_q >> 1);
				den_q <= {len_q, {FRAC_W{1'b0}}};
				quo_q <= '0;
			end
			NS_DIV: begin
				if (ge) rem_q <= rem_q - den_q;
				den_q <= den_q >> 1;
				quo_q <= quo_next;
				if (step_q == 4'(QUO_W - 1)) begin
					if (len_q == '0) res_q[comp_q] <= '0;
					else res_q[comp_q] <= neg_q[comp_q] ? -quo_ext : quo_ext;
				end
			end
			default: ;
		endcase
	end

	assign n0 = res_q[0];
	assign n1 = res_q[1];
	assign n2 = res_q[2];

endmodule

// ===== rtl/smooth_vertex_normals_unit.sv =====
// load and error items go straight to the result; read and add items pass the normalising unit,
// and an add item first shifts a large cross product down until it fits; a clear item sweeps
// every accumulator. one item at a time, set by the shared normalising unit
// (bit-serial square root and division) and the accumulator read-modify-write sweeps.
// reset: vertex_count returns to 1024 and a clearing pass zeroes the accumulators
// while no item is accepted; positions are undefined until loaded.
module smooth_vertex_normals_unit #(
	parameter int MAX_VERTS  = 1024,
	parameter int ACCUM_BITS = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [10:0]          cfg_wr_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           opcode,
	input  logic [9:0]           index_a,
	input  logic [9:0]           index_b,
	input  logic [9:0]           index_c,
	input  svn_pkg::pos_t        pos_x,
	input  svn_pkg::pos_t        pos_y,
	input  svn_pkg::pos_t        pos_z,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 status,
	output svn_pkg::q14_t        normal_x,
	output svn_pkg::q14_t        normal_y,
	output svn_pkg::q14_t        normal_z
);

	import svn_pkg::*;

	localparam int AW = $clog2(MAX_VERTS);
	localparam int AB = ACCUM_BITS;
	localparam logic [AW-1:0] LAST = AW'(MAX_VERTS - 1);

	state_t state_q, state_d;

	logic [CNT_W-1:0]     vcount_q;
	logic [AW-1:0]        clr_cnt_q;
	logic                 resp_q;
	op_t                  op_q;
	logic                 err_q;
	logic [AW-1:0]        idx_q [3];
	logic [1:0]           corner_q;
	logic [2:0]           mcnt_q;
	logic signed [POS_W-1:0] p0_q [3];
	logic signed [POS_W:0] e1_q [3];
	logic signed [POS_W:0] e2_q [3];
	logic signed [2*POS_W+1:0] prod_q;
	vec_t                 nin_q [3];

	logic                 out_valid_q;
	logic                 status_q;
	q14_t                 nx_q, ny_q, nz_q;

	logic                 in_accept;
	op_t                  in_op;
	logic [31:0]          lim;
	logic                 err_a, err_abc;
	logic                 pos_we;
	logic [AW-1:0]        pos_raddr;
	logic [3*POS_W-1:0]   pos_rdata;
	logic                 acc_we;
	logic [AW-1:0]        acc_waddr, acc_raddr;
	logic [3*AB-1:0]      acc_wdata, acc_rdata;
	logic                 norm_start, norm_done;
	q14_t                 n0, n1, n2;
	logic                 out_load;
	logic signed [POS_W:0] ma, mb;
	logic [2:0]           mk;

	function automatic logic [AB-1:0] sat_add(input logic [AB-1:0] a, input q14_t n);
		logic signed [AB:0] s;
		logic [AB-1:0]      r;
		s = $signed({a[AB-1], a}) + $signed({{(AB-Q14_W+1){n[Q14_W-1]}}, n});
		if (s[AB] != s[AB-1]) r = s[AB] ? {1'b1, {(AB-1){1'b0}}} : {1'b0, {(AB-1){1'b1}}};
		else r = s[AB-1:0];
		return r;
	endfunction

	assign in_op     = op_t'(opcode);
	assign in_accept = in_valid && !in_stall;
	assign lim       = (32'(vcount_q) < 32'(MAX_VERTS)) ? 32'(vcount_q) : 32'(MAX_VERTS);
	assign err_a     = 32'(index_a) >= lim;
	assign err_abc   = err_a || (32'(index_b) >= lim) || (32'(index_c) >= lim);
	assign mk        = mcnt_q - 3'd1;

	svn_ram #(.W(3*POS_W), .D(MAX_VERTS)) u_pos (
		.clk   (clk),
		.we    (pos_we),
		.waddr (AW'(index_a)),
		.wdata ({pos_z, pos_y, pos_x}),
		.raddr (pos_raddr),
		.rdata (pos_rdata)
	);

	svn_ram #(.W(3*AB), .D(MAX_VERTS)) u_acc (
		.clk   (clk),
		.we    (acc_we),
		.waddr (acc_waddr),
		.wdata (acc_wdata),
		.raddr (acc_raddr),
		.rdata (acc_rdata)
	);

	svn_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (norm_start),
		.v0     (nin_q[0]),
		.v1     (nin_q[1]),
		.v2     (nin_q[2]),
		.done   (norm_done),
		.n0     (n0),
		.n1     (n1),
		.n2     (n2)
	);

	// cross product operand pairs, two per component
	always_comb begin
		unique case (mcnt_q)
			3'd0:    begin ma = e1_q[1]; mb = e2_q[2]; end
			3'd1:    begin ma = e1_q[2]; mb = e2_q[1]; end
			3'd2:    begin ma = e1_q[2]; mb = e2_q[0]; end
			3'd3:    begin ma = e1_q[0]; mb = e2_q[2]; end
			3'd4:    begin ma = e1_q[0]; mb = e2_q[1]; end
			3'd5:    begin ma = e1_q[1]; mb = e2_q[0]; end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_stall   = 1'b1;
		pos_we     = 1'b0;
		pos_raddr  = idx_q[0];
		acc_we     = 1'b0;
		acc_waddr  = idx_q[corner_q];
		acc_raddr  = idx_q[corner_q];
		acc_wdata  = {sat_add(acc_rdata[3*AB-1:2*AB], n2),
			sat_add(acc_rdata[2*AB-1:AB], n1), sat_add(acc_rdata[AB-1:0], n0)};
		norm_start = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				acc_we    = 1'b1;
				acc_waddr = clr_cnt_q;
				acc_wdata = '0;
				if (clr_cnt_q == LAST) state_d = resp_q ? ST_DONE : ST_IDLE;
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					unique case (in_op)
						OP_LOAD: begin
							pos_we  = !err_a;
							state_d = ST_DONE;
						end
						OP_CLEAR: state_d = ST_CLEAR;
						OP_ADD:   state_d = err_abc ? ST_DONE : ST_POS_A;
						OP_READ:  state_d = err_a ? ST_DONE : ST_RD_ADDR;
						default:  state_d = ST_DONE;
					endcase
				end
			end
			ST_POS_A: begin
				pos_raddr = idx_q[0];
				state_d   = ST_POS_B;
			end
			ST_POS_B: begin
				pos_raddr = idx_q[1];
				state_d   = ST_POS_C;
			end
			ST_POS_C: begin
				pos_raddr = idx_q[2];
				state_d   = ST_POS_CAP;
			end
			ST_POS_CAP: state_d = ST_CROSS;
			ST_CROSS:   if (mcnt_q == 3'd6) state_d = ST_NORM_START;
			ST_RD_ADDR: begin
				acc_raddr = idx_q[0];
				state_d   = ST_RD_DATA;
			end
			ST_RD_DATA: state_d = ST_NORM_START;
			ST_NORM_START: begin
				norm_start = 1'b1;
				state_d    = ST_NORM_WAIT;
			end
			ST_NORM_WAIT: begin
				if (norm_done) state_d = (op_q == OP_ADD) ? ST_ACC_RD : ST_DONE;
			end
			ST_ACC_RD: state_d = ST_ACC_WR;
			ST_ACC_WR: begin
				acc_we  = 1'b1;
				state_d = (corner_q == 2'd2) ? ST_DONE : ST_ACC_RD;
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q    <= 11'd1024;
			clr_cnt_q   <= '0;
			resp_q      <= 1'b0;
			op_q        <= OP_LOAD;
			err_q       <= 1'b0;
			corner_q    <= '0;
			mcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) vcount_q <= cfg_wr_data;
			if (state_q == ST_CLEAR) clr_cnt_q <= (clr_cnt_q == LAST) ? '0 : clr_cnt_q + 1'b1;
			if (in_accept) begin
				op_q     <= in_op;
				err_q    <= (in_op == OP_ADD) ? err_abc
					: ((in_op == OP_CLEAR) ? 1'b0 : err_a);
				resp_q   <= 1'b1;
				corner_q <= '0;
				mcnt_q   <= '0;
			end
			if (state_q == ST_CROSS) mcnt_q <= mcnt_q + 3'd1;
			if (state_q == ST_ACC_WR) corner_q <= corner_q + 2'd1;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			idx_q[0] <= AW'(index_a);
			idx_q[1] <= AW'(index_b);
			idx_q[2] <= AW'(index_c);
		end
		unique case (state_q)
			ST_POS_B: begin
				p0_q[0] <= pos_rdata[POS_W-1:0];
				p0_q[1] <= pos_rdata[2*POS_W-1:POS_W];
				p0_q[2] <= pos_rdata[3*POS_W-1:2*POS_W];
			end
			ST_POS_C: begin
				e1_q[0] <= $signed(pos_rdata[POS_W-1:0]) - p0_q[0];
				e1_q[1] <= $signed(pos_rdata[2*POS_W-1:POS_W]) - p0_q[1];
				e1_q[2] <= $signed(pos_rdata[3*POS_W-1:2*POS_W]) - p0_q[2];
			end
			ST_POS_CAP: begin
				e2_q[0] <= $signed(pos_rdata[POS_W-1:0]) - p0_q[0];
				e2_q[1] <= $signed(pos_rdata[2*POS_W-1:POS_W]) - p0_q[1];
				e2_q[2] <= $signed(pos_rdata[3*POS_W-1:2*POS_W]) - p0_q[2];
			end
			ST_CROSS: begin
				prod_q <= ma * mb;
				// first product of a pair sets the component, second subtracts
				if (mcnt_q != 3'd0) begin
					if (!mk[0]) nin_q[mk[2:1]] <= VEC_W'(prod_q);
					else nin_q[mk[2:1]] <= nin_q[mk[2:1]] - VEC_W'(prod_q);
				end
			end
			ST_RD_DATA: begin
				nin_q[0] <= VEC_W'($signed(acc_rdata[AB-1:0]));
				nin_q[1] <= VEC_W'($signed(acc_rdata[2*AB-1:AB]));
				nin_q[2] <= VEC_W'($signed(acc_rdata[3*AB-1:2*AB]));
			end
			default: ;
		endcase
		if (out_load) begin
			status_q <= err_q;
			if (op_q == OP_READ && !err_q) begin
				nx_q <= n0;
				ny_q <= n1;
				nz_q <= n2;
			end else begin
				nx_q <= '0;
				ny_q <= '0;
				nz_q <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign normal_x  = nx_q;
	assign normal_y  = ny_q;
	assign normal_z  = nz_q;

endmodule

// ===== dv/smooth_vertex_normals_unit_tb.sv =====
module smooth_vertex_normals_unit_tb;
	import svn_pkg::*;

	localparam int NVERT     = 1024;
	localparam int ACC_MAX   = (1 << 23) - 1;
	localparam int ACC_MIN   = -(1 << 23);
	localparam int IDLE_LIMIT = 6000;

	typedef struct {
		logic status;
		q14_t nx;
		q14_t ny;
		q14_t nz;
	} normal_item_t;

	class normal_scoreboard;
		longint pos[NVERT][3];
		longint acc[NVERT][3];
		bit loaded[NVERT];
		int vcount;
		int errors;
		normal_item_t pending_normals[$];

		function new();
			vcount = 1024;
			errors = 0;
			foreach (acc[i, k]) acc[i][k] = 0;
			foreach (loaded[i]) loaded[i] = 0;
		endfunction

		function int lim();
			return vcount < NVERT ? vcount : NVERT;
		endfunction

		function longint unsigned int_sqrt(longint unsigned v);
			longint unsigned r;
			longint unsigned b;
			r = 0;
			b = 64'h4000_0000_0000_0000;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		function void unit_vec(input longint v[3], output longint n[3]);
			longint unsigned m[3];
			longint unsigned mx;
			longint unsigned sum;
			longint unsigned len;
			longint q;
			mx = 0;
			sum = 0;
			for (int i = 0; i < 3; i++) begin
				m[i] = v[i] < 0 ? -v[i] : v[i];
				if (m[i] > mx) mx = m[i];
			end
			while (mx >= (64'd1 << 30)) begin
				mx >>= 1;
				for (int i = 0; i < 3; i++) m[i] >>= 1;
			end
			for (int i = 0; i < 3; i++) sum += m[i] * m[i];
			len = int_sqrt(sum);
			for (int i = 0; i < 3; i++) begin
				if (len == 0) begin
					n[i] = 0;
				end else begin
					q = (m[i] * 16384 + len / 2) / len;
					n[i] = v[i] < 0 ? -q : q;
				end
			end
		endfunction

		function void note_item(op_t op, int a, int b, int c, pos_t x, pos_t y, pos_t z);
			normal_item_t e;
			longint e1[3];
			longint e2[3];
			longint cr[3];
			longint n[3];
			longint s;
			int idx[3];
			e = '{1'b0, '0, '0, '0};
			idx = '{a, b, c};
			case (op)
				OP_LOAD: begin
					if (a >= lim()) begin
						e.status = 1'b1;
					end else begin
						pos[a][0] = x;
						pos[a][1] = y;
						pos[a][2] = z;
						loaded[a] = 1;
					end
				end
				OP_CLEAR: begin
					foreach (acc[i, k]) acc[i][k] = 0;
				end
				OP_ADD: begin
					if (a >= lim() || b >= lim() || c >= lim()) begin
						e.status = 1'b1;
					end else begin
						for (int k = 0; k < 3; k++) begin
							e1[k] = pos[b][k] - pos[a][k];
							e2[k] = pos[c][k] - pos[a][k];
						end
						cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
						cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
						cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
						unit_vec(cr, n);
						// a repeated corner collects the normal twice
						for (int i = 0; i < 3; i++)
							for (int k = 0; k < 3; k++) begin
								s = acc[idx[i]][k] + n[k];
								if (s > ACC_MAX) s = ACC_MAX;
								if (s < ACC_MIN) s = ACC_MIN;
								acc[idx[i]][k] = s;
							end
					end
				end
				default: begin
					if (a >= lim()) begin
						e.status = 1'b1;
					end else begin
						unit_vec(acc[a], n);
						e.nx = 16'(n[0]);
						e.ny = 16'(n[1]);
						e.nz = 16'(n[2]);
					end
				end
			endcase
			pending_normals = {pending_normals, e};
		endfunction

		task report(string what);
			$display("mismatch: %s", what);
			errors++;
		endtask

		task check_result(logic st, q14_t nx, q14_t ny, q14_t nz);
			normal_item_t e;
			if (pending_normals.size() == 0) begin
				report("result with no item outstanding");
				return;
			end
			e = pending_normals.pop_front();
			if (st !== e.status || nx !== e.nx || ny !== e.ny || nz !== e.nz)
				report($sformatf("got st=%0d n=(%0d,%0d,%0d) want st=%0d n=(%0d,%0d,%0d)",
					st, nx, ny, nz, e.status, e.nx, e.ny, e.nz));
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_wr_en = 0;
	logic [10:0] cfg_wr_data = '0;
	logic in_valid = 0;
	logic in_stall;
	logic [1:0] opcode = '0;
	logic [9:0] index_a = '0;
	logic [9:0] index_b = '0;
	logic [9:0] index_c = '0;
	pos_t pos_x = '0;
	pos_t pos_y = '0;
	pos_t pos_z = '0;
	logic out_valid;
	logic out_stall = 0;
	logic status;
	q14_t normal_x;
	q14_t normal_y;
	q14_t normal_z;

	normal_scoreboard sb = new();
	bit steady_in;
	bit steady_out;
	int stall_left = 0;
	int quiet_cycles = 0;

	smooth_vertex_normals_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .index_a(index_a), .index_b(index_b), .index_c(index_c),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// result side: random stall, checked on accepted items
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			sb.check_result(status, normal_x, normal_y, normal_z);
		if (steady_out || stall_left == 0) begin
			stall_left <= steady_out ? 0 : gap_len();
			out_stall <= 0;
		end else begin
			stall_left <= stall_left - 1;
			out_stall <= 1;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("[smooth_vertex_normals_unit] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task send_item(op_t op, int a, int b, int c, int x, int y, int z);
		int g;
		pos_t px;
		pos_t py;
		pos_t pz;
		px = 16'(x);
		py = 16'(y);
		pz = 16'(z);
		opcode <= op;
		index_a <= 10'(a);
		index_b <= 10'(b);
		index_c <= 10'(c);
		pos_x <= px;
		pos_y <= py;
		pos_z <= pz;
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
		sb.note_item(op, a, b, c, px, py, pz);
		g = steady_in ? 0 : gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	task write_count(int v);
		in_valid <= 0;
		while (sb.pending_normals.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wr_en <= 1;
		cfg_wr_data <= 11'(v);
		@(posedge clk);
		cfg_wr_en <= 0;
		sb.vcount = v;
	endtask

	// in-range corner that holds a position, or -1 if none
	function int loaded_vertex();
		int cand[$];
		for (int i = 0; i < sb.lim(); i++)
			if (sb.loaded[i]) cand = {cand, i};
		if (cand.size() == 0) return -1;
		if ($urandom_range(0, 3) != 0)
			foreach (cand[i]) if (cand[i] < 16) return cand[$urandom_range(0, i)];
		return cand[$urandom_range(0, cand.size() - 1)];
	endfunction

	function int corner();
		int v;
		if (sb.lim() < NVERT && $urandom_range(0, 9) == 0)
			return $urandom_range(sb.lim(), NVERT - 1);
		v = loaded_vertex();
		return v;
	endfunction

	task random_item();
		int r;
		int a;
		int b;
		int c;
		r = $urandom_range(0, 99);
		a = corner();
		b = corner();
		c = corner();
		if (r < 45 && a >= 0 && b >= 0 && c >= 0) begin
			send_item(OP_ADD, a, b, c, $urandom, $urandom, $urandom);
		end else if (r < 70 || a < 0 || b < 0 || c < 0) begin
			a = $urandom_range(0, 3) == 0 ? $urandom_range(0, NVERT - 1) : $urandom_range(0, 15);
			send_item(OP_LOAD, a, $urandom, $urandom, $urandom, $urandom, $urandom);
		end else if (r < 74) begin
			send_item(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		end else begin
			a = $urandom_range(0, 1) ? $urandom_range(0, NVERT - 1) : $urandom_range(0, 15);
			send_item(OP_READ, a, $urandom, $urandom, $urandom, $urandom, $urandom);
		end
	endtask

	initial begin
		int counts[5];
		counts = '{2047, 3, 1, 16, 1024};
		steady_in = 0;
		steady_out = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// extremes of position, degenerate and repeated corners, zero accumulator
		send_item(OP_LOAD, 0, 0, 0, -32768, -32768, -32768);
		send_item(OP_LOAD, 1023, 0, 0, 32767, 32767, 32767);
		send_item(OP_LOAD, 1, 0, 0, 32767, -32768, 0);
		send_item(OP_LOAD, 2, 0, 0, 0, 32767, -32768);
		send_item(OP_LOAD, 3, 0, 0, -32768, 0, 32767);
		send_item(OP_ADD, 0, 1, 2, 0, 0, 0);
		send_item(OP_ADD, 1023, 2, 3, 0, 0, 0);
		send_item(OP_ADD, 0, 0, 1, 0, 0, 0);
		send_item(OP_ADD, 3, 3, 3, 0, 0, 0);
		send_item(OP_ADD, 0, 1023, 3, 0, 0, 0);
		send_item(OP_READ, 0, 0, 0, 0, 0, 0);
		send_item(OP_READ, 1023, 0, 0, 0, 0, 0);
		send_item(OP_READ, 3, 0, 0, 0, 0, 0);
		send_item(OP_READ, 5, 0, 0, 0, 0, 0);
		write_count(3);
		send_item(OP_LOAD, 3, 0, 0, 1, 1, 1);
		send_item(OP_ADD, 0, 1, 1023, 0, 0, 0);
		send_item(OP_ADD, 2, 1023, 1, 0, 0, 0);
		send_item(OP_READ, 3, 0, 0, 0, 0, 0);
		send_item(OP_READ, 2, 0, 0, 0, 0, 0);
		send_item(OP_CLEAR, 0, 0, 0, 0, 0, 0);
		send_item(OP_READ, 0, 0, 0, 0, 0, 0);

		foreach (counts[p]) begin
			write_count(counts[p]);
			for (int i = 0; i < 50; i++) begin
				steady_in = (i % 40) >= 30;
				steady_out = (i % 40) >= 25 && (i % 40) < 35;
				random_item();
			end
		end

		// drive one vertex's accumulator into saturation and back
		steady_in = 0;
		steady_out = 0;
		send_item(OP_CLEAR, 0, 0, 0, 0, 0, 0);
		send_item(OP_LOAD, 0, 0, 0, 0, 0, 0);
		send_item(OP_LOAD, 1, 0, 0, 256, 0, 0);
		send_item(OP_LOAD, 2, 0, 0, 0, 256, 0);
		for (int i = 0; i < 540; i++) begin
			if (i % 60 == 0) send_item(OP_READ, 0, 0, 0, 0, 0, 0);
			send_item(OP_ADD, 0, 1, 2, 0, 0, 0);
		end
		for (int i = 0; i < 20; i++)
			send_item(OP_ADD, 0, 2, 1, 0, 0, 0);
		send_item(OP_READ, 0, 0, 0, 0, 0, 0);

		in_valid <= 0;
		while (sb.pending_normals.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.pending_normals.size() == 0 && sb.errors == 0)
			$display("[smooth_vertex_normals_unit] OK");
		else
			$display("[smooth_vertex_normals_unit] ERROR");
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/svn_pkg.sv
rtl/svn_ram.sv
rtl/svn_norm.sv
rtl/smooth_vertex_normals_unit.sv
dv/smooth_vertex_normals_unit_tb.sv
